// ----- src/ordered_list_store_core_macros.svh -----
// ----------------------------------------------------------------------------
// Ordered list store assertion macros
// Shared assertion wrappers. With SYNTH defined they expand to nothing.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_STORE_CORE_MACROS_SVH
`define ORDERED_LIST_STORE_CORE_MACROS_SVH

`ifndef SYNTH

// A property that must hold at every clock edge outside reset.
`define OLS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ordered list store: assertion failed");

// A condition that forces a consequence at the next clock edge.
`define OLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ordered list store: assertion failed");

`else

`define OLS_ASSERT(lbl, clk, rst_n, prop)
`define OLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/ols_pkg.sv -----
// ----------------------------------------------------------------------------
// Ordered list store package
// Sizes, command and status codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package ols_pkg;

  // List capacity and derived widths.
  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VAL_W   = 32;
  localparam int POS_W   = 5;
  localparam int CMD_W   = 3;
  localparam int ST_W    = 3;
  localparam int CMP_W   = POS_W + CNT_W;

  // Stream payload widths.
  localparam int IN_DATA_W  = ((VAL_W + POS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((ST_W + VAL_W + 7) / 8) * 8;

  // Request commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT   = 3'd0,
    CMD_PUSH_BACK    = 3'd1,
    CMD_INSERT_AFTER = 3'd2,
    CMD_POP_FRONT    = 3'd3,
    CMD_POP_BACK     = 3'd4,
    CMD_DELETE_VALUE = 3'd5,
    CMD_READ_ALL     = 3'd6
  } cmd_t;

  // Result status codes.
  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_BAD_POS   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } st_t;

  // Datapath operations issued by the controller.
  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD,
    DP_INSERT,
    DP_REMOVE,
    DP_MATCH,
    DP_READ
  } dp_op_t;

  // Controller to datapath command.
  typedef struct packed {
    dp_op_t op;
    logic   emit;
    st_t    status;
    logic   take_entry;
    logic   last;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             empty;
    logic             pos_bad;
    logic             match_any;
    logic             read_last;
    logic             out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- src/ols_dpath.sv -----
// ----------------------------------------------------------------------------
// Ordered list store datapath
// List cells with positional shift, entry count, parallel value compare,
// read-out index and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ordered_list_store_core_macros.svh"

module ols_dpath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ols_pkg::dp_cmd_t              ctl,
  output      ols_pkg::dp_sts_t              sts,
  input  wire logic [ols_pkg::CMD_W-1:0]     in_cmd,
  input  wire logic [ols_pkg::VAL_W-1:0]     in_value,
  input  wire logic [ols_pkg::POS_W-1:0]     in_pos,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [ols_pkg::ST_W-1:0]      out_status,
  output      logic [ols_pkg::VAL_W-1:0]     out_value,
  output      logic                          out_last
);

  // Request fields held for the duration of the command.
  logic [ols_pkg::CMD_W-1:0] cmd_r;
  logic [ols_pkg::VAL_W-1:0] val_r;
  logic [ols_pkg::POS_W-1:0] pos_r;

  // List cells, entry 0 is the front.
  logic [ols_pkg::VAL_W-1:0] cell_r   [ols_pkg::DEPTH];
  logic [ols_pkg::VAL_W-1:0] cell_nxt [ols_pkg::DEPTH];

  logic [ols_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ols_pkg::IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [ols_pkg::DEPTH-1:0] match_r, match_nxt;

  logic [ols_pkg::IDX_W-1:0] ins_slot;
  logic [ols_pkg::IDX_W-1:0] rem_slot;
  logic [ols_pkg::IDX_W-1:0] first_idx;
  logic [ols_pkg::IDX_W-1:0] rd_addr;
  logic [ols_pkg::VAL_W-1:0] entry;

  logic                      out_valid_r;
  logic [ols_pkg::ST_W-1:0]  out_status_r;
  logic [ols_pkg::VAL_W-1:0] out_value_r;
  logic                      out_last_r;

  // Lowest matching slot wins.
  always_comb begin
    first_idx = '0;
    for (int i = ols_pkg::DEPTH - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        first_idx = ols_pkg::IDX_W'(i);
      end
    end
  end

  // Slot that an insert opens.
  always_comb begin
    case (cmd_r)
      ols_pkg::CMD_PUSH_FRONT:   ins_slot = '0;
      ols_pkg::CMD_PUSH_BACK:    ins_slot = ols_pkg::IDX_W'(cnt_r);
      ols_pkg::CMD_INSERT_AFTER: ins_slot = ols_pkg::IDX_W'(pos_r);
      default:                   ins_slot = '0;
    endcase
  end

  // Slot that a removal closes.
  always_comb begin
    case (cmd_r)
      ols_pkg::CMD_POP_FRONT:    rem_slot = '0;
      ols_pkg::CMD_POP_BACK:     rem_slot = ols_pkg::IDX_W'(cnt_r - ols_pkg::CNT_W'(1));
      ols_pkg::CMD_DELETE_VALUE: rem_slot = first_idx;
      default:                   rem_slot = '0;
    endcase
  end

  // Single read port shared by removal and read-out.
  assign rd_addr = (ctl.op == ols_pkg::DP_READ) ? rd_idx_r : rem_slot;
  assign entry   = cell_r[rd_addr];

  // Cell shifting for insert and remove.
  always_comb begin
    for (int i = 0; i < ols_pkg::DEPTH; i++) begin
      cell_nxt[i] = cell_r[i];
    end
    case (ctl.op)
      ols_pkg::DP_INSERT: begin
        for (int i = 1; i < ols_pkg::DEPTH; i++) begin
          if (ols_pkg::IDX_W'(i) > ins_slot) begin
            cell_nxt[i] = cell_r[i-1];
          end
        end
        cell_nxt[ins_slot] = val_r;
      end
      ols_pkg::DP_REMOVE: begin
        for (int i = 0; i < ols_pkg::DEPTH - 1; i++) begin
          if (ols_pkg::IDX_W'(i) >= rem_slot) begin
            cell_nxt[i] = cell_r[i+1];
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Count, read index and compare vector.
  always_comb begin
    cnt_nxt    = cnt_r;
    rd_idx_nxt = rd_idx_r;
    match_nxt  = match_r;
    case (ctl.op)
      ols_pkg::DP_LOAD:   rd_idx_nxt = '0;
      ols_pkg::DP_INSERT: cnt_nxt = cnt_r + ols_pkg::CNT_W'(1);
      ols_pkg::DP_REMOVE: cnt_nxt = cnt_r - ols_pkg::CNT_W'(1);
      ols_pkg::DP_READ:   rd_idx_nxt = rd_idx_r + ols_pkg::IDX_W'(1);
      ols_pkg::DP_MATCH: begin
        for (int i = 0; i < ols_pkg::DEPTH; i++) begin
          match_nxt[i] = (cell_r[i] == val_r) && (ols_pkg::CNT_W'(i) < cnt_r);
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rd_idx_r <= '0;
    end else begin
      cnt_r    <= cnt_nxt;
      rd_idx_r <= rd_idx_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    match_r <= match_nxt;
    for (int i = 0; i < ols_pkg::DEPTH; i++) begin
      cell_r[i] <= cell_nxt[i];
    end
    if (ctl.op == ols_pkg::DP_LOAD) begin
      cmd_r <= in_cmd;
      val_r <= in_value;
      pos_r <= in_pos;
    end
  end

  // Result output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_status_r <= ctl.status;
      out_value_r  <= ctl.take_entry ? entry : '0;
      out_last_r   <= ctl.last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;
  assign out_last   = out_last_r;

  // Status toward the controller.
  always_comb begin
    sts.cmd       = cmd_r;
    sts.full      = (cnt_r == ols_pkg::CNT_W'(ols_pkg::DEPTH));
    sts.empty     = (cnt_r == '0);
    sts.pos_bad   = (pos_r == '0) ||
                    (ols_pkg::CMP_W'(pos_r) > ols_pkg::CMP_W'(cnt_r));
    sts.match_any = |match_r;
    sts.read_last = (ols_pkg::CNT_W'(rd_idx_r) == (cnt_r - ols_pkg::CNT_W'(1)));
    sts.out_free  = !out_valid_r || out_ready;
  end

  // The count never passes the capacity.
  `OLS_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= ols_pkg::CNT_W'(ols_pkg::DEPTH))
  // An insert grows the list by exactly one.
  `OLS_ASSERT_NEXT(a_ins_grow, clk, rst_n, ctl.op == ols_pkg::DP_INSERT,
    cnt_r == $past(cnt_r) + ols_pkg::CNT_W'(1))
  // A removal is only issued on a list that holds something.
  `OLS_ASSERT(a_rem_nonempty, clk, rst_n, (ctl.op != ols_pkg::DP_REMOVE) || (cnt_r != '0))

endmodule

`default_nettype wire

// ----- src/ols_ctrl.sv -----
// ----------------------------------------------------------------------------
// Ordered list store controller
// Sequences each request: capture, execute, optional search or read-out,
// and issues datapath operations and result strobes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ordered_list_store_core_macros.svh"

module ols_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output      logic             in_ready,
  input  wire ols_pkg::dp_sts_t sts,
  output      ols_pkg::dp_cmd_t ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FIND,
    S_READ
  } state_t;

  state_t state_r, state_nxt;

  // Emit a single result with the given status.
  function automatic ols_pkg::dp_cmd_t result(input ols_pkg::dp_op_t op,
                                              input ols_pkg::st_t st,
                                              input logic take);
    ols_pkg::dp_cmd_t c;
    c.op         = op;
    c.emit       = 1'b1;
    c.status     = st;
    c.take_entry = take;
    c.last       = 1'b1;
    return c;
  endfunction

  assign in_ready = (state_r == S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_nxt      = state_r;
    ctl.op         = ols_pkg::DP_NOP;
    ctl.emit       = 1'b0;
    ctl.status     = ols_pkg::ST_OK;
    ctl.take_entry = 1'b0;
    ctl.last       = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.op    = ols_pkg::DP_LOAD;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.cmd)
          ols_pkg::CMD_PUSH_FRONT, ols_pkg::CMD_PUSH_BACK: begin
            if (sts.out_free) begin
              state_nxt = S_IDLE;
              if (sts.full) begin
                ctl = result(ols_pkg::DP_NOP, ols_pkg::ST_FULL, 1'b0);
              end else begin
                ctl = result(ols_pkg::DP_INSERT, ols_pkg::ST_OK, 1'b0);
              end
            end
          end
          ols_pkg::CMD_INSERT_AFTER: begin
            if (sts.out_free) begin
              state_nxt = S_IDLE;
              if (sts.full) begin
                ctl = result(ols_pkg::DP_NOP, ols_pkg::ST_FULL, 1'b0);
              end else if (sts.pos_bad) begin
                ctl = result(ols_pkg::DP_NOP, ols_pkg::ST_BAD_POS, 1'b0);
              end else begin
                ctl = result(ols_pkg::DP_INSERT, ols_pkg::ST_OK, 1'b0);
              end
            end
          end
          ols_pkg::CMD_POP_FRONT, ols_pkg::CMD_POP_BACK: begin
            if (sts.out_free) begin
              state_nxt = S_IDLE;
              if (sts.empty) begin
                ctl = result(ols_pkg::DP_NOP, ols_pkg::ST_EMPTY, 1'b0);
              end else begin
                ctl = result(ols_pkg::DP_REMOVE, ols_pkg::ST_OK, 1'b1);
              end
            end
          end
          ols_pkg::CMD_DELETE_VALUE: begin
            if (!sts.empty) begin
              ctl.op    = ols_pkg::DP_MATCH;
              state_nxt = S_FIND;
            end else if (sts.out_free) begin
              ctl       = result(ols_pkg::DP_NOP, ols_pkg::ST_EMPTY, 1'b0);
              state_nxt = S_IDLE;
            end
          end
          ols_pkg::CMD_READ_ALL: begin
            if (!sts.empty) begin
              state_nxt = S_READ;
            end else if (sts.out_free) begin
              ctl       = result(ols_pkg::DP_NOP, ols_pkg::ST_EMPTY, 1'b0);
              state_nxt = S_IDLE;
            end
          end
          default: begin
            // Unused command code: dropped without a result.
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_FIND: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
          if (sts.match_any) begin
            ctl = result(ols_pkg::DP_REMOVE, ols_pkg::ST_OK, 1'b1);
          end else begin
            ctl = result(ols_pkg::DP_NOP, ols_pkg::ST_NOT_FOUND, 1'b0);
          end
        end
      end
      S_READ: begin
        if (sts.out_free) begin
          ctl      = result(ols_pkg::DP_READ, ols_pkg::ST_OK, 1'b1);
          ctl.last = sts.read_last;
          if (sts.read_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A result is only loaded when the output register can take it.
  `OLS_ASSERT(a_emit_free, clk, rst_n, !ctl.emit || sts.out_free)
  // The final read-out element returns the controller to idle.
  `OLS_ASSERT_NEXT(a_read_done, clk, rst_n,
    (state_r == S_READ) && ctl.emit && ctl.last, state_r == S_IDLE)

endmodule

`default_nettype wire

// ----- src/ordered_list_store_core.sv -----
// Sequencing: an accepted request is captured, then executed; the result is loaded
// into the output register once it is free. Delete by value first registers a
// compare vector; read all emits the elements in order via the single list read
// port. A new request is taken only after the last result of the previous one.
// Reset: synchronous, active low; clears the entry count, controller and output
// valid. List contents are left as they are.
// ----------------------------------------------------------------------------
// Ordered list store core
// Bounded ordered list of signed 32-bit values with front/back/positional
// insert, front/back/by-value delete and in-order read-out.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_store_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output      logic                               in_tready,
  // item_value [31:0], position [36:32], zero fill above
  input  wire logic [ols_pkg::IN_DATA_W-1:0]      in_tdata,
  // command [2:0]
  input  wire logic [ols_pkg::CMD_W-1:0]          in_tuser,
  output      logic                               out_tvalid,
  input  wire logic                               out_tready,
  // status [2:0], result_value [34:3], zero fill above
  output      logic [ols_pkg::OUT_DATA_W-1:0]     out_tdata,
  output      logic                               out_tlast
);

  ols_pkg::dp_cmd_t ctl;
  ols_pkg::dp_sts_t sts;

  logic [ols_pkg::ST_W-1:0]  out_status;
  logic [ols_pkg::VAL_W-1:0] out_value;

  ols_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  ols_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .sts        (sts),
    .in_cmd     (in_tuser),
    .in_value   (in_tdata[ols_pkg::VAL_W-1:0]),
    .in_pos     (in_tdata[ols_pkg::VAL_W +: ols_pkg::POS_W]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_status),
    .out_value  (out_value),
    .out_last   (out_tlast)
  );

  // Pack the result fields, status in the low bits.
  assign out_tdata = ols_pkg::OUT_DATA_W'({out_value, out_status});

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ordered list store testbench
// Streams list requests into the core with random gaps and output stalls.
// A scoreboard keeps its own copy of the list, predicts every result of each
// accepted request, and checks the returned results in order.
// ----------------------------------------------------------------------------

module tb_top;
  import ols_pkg::*;

  // Command code that the core must ignore.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int RANDOM_REQUESTS = 410;
  localparam int DRAIN_CYCLES    = 40;

  // One expected result of a request.
  typedef struct {
    logic [ST_W-1:0]  status;
    logic [VAL_W-1:0] value;
    logic             last;
  } list_result_t;

  // Shadow list plus the queue of results still owed by the core.
  class list_scoreboard;
    logic [VAL_W-1:0] shadow_list[$];
    list_result_t     pending_results[$];
    int unsigned      mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    function void owe_result(st_t st, logic [VAL_W-1:0] v, logic lst);
      list_result_t r;
      r.status = st;
      r.value  = v;
      r.last   = lst;
      pending_results.push_back(r);
    endfunction

    // Apply an accepted request to the shadow list and queue its results.
    function void note_request(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] v,
                               logic [POS_W-1:0] pos);
      int  idx;
      bit  found;
      case (cmd)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (shadow_list.size() >= DEPTH) begin
            owe_result(ST_FULL, '0, 1'b1);
          end else begin
            if (cmd == CMD_PUSH_FRONT) shadow_list.push_front(v);
            else shadow_list.push_back(v);
            owe_result(ST_OK, '0, 1'b1);
          end
        end
        CMD_INSERT_AFTER: begin
          // The full check wins over a bad position.
          if (shadow_list.size() >= DEPTH) begin
            owe_result(ST_FULL, '0, 1'b1);
          end else if (pos == 0 || pos > shadow_list.size()) begin
            owe_result(ST_BAD_POS, '0, 1'b1);
          end else begin
            if (pos == shadow_list.size()) shadow_list.push_back(v);
            else shadow_list.insert(pos, v);
            owe_result(ST_OK, '0, 1'b1);
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK: begin
          if (shadow_list.size() == 0) owe_result(ST_EMPTY, '0, 1'b1);
          else if (cmd == CMD_POP_FRONT) owe_result(ST_OK, shadow_list.pop_front(), 1'b1);
          else owe_result(ST_OK, shadow_list.pop_back(), 1'b1);
        end
        CMD_DELETE_VALUE: begin
          found = 1'b0;
          if (shadow_list.size() == 0) begin
            owe_result(ST_EMPTY, '0, 1'b1);
          end else begin
            // Only the first matching entry is removed.
            for (idx = 0; idx < shadow_list.size() && !found; idx++) begin
              if (shadow_list[idx] == v) begin
                found = 1'b1;
                owe_result(ST_OK, shadow_list[idx], 1'b1);
                shadow_list.delete(idx);
              end
            end
            if (!found) owe_result(ST_NOT_FOUND, '0, 1'b1);
          end
        end
        CMD_READ_ALL: begin
          if (shadow_list.size() == 0) begin
            owe_result(ST_EMPTY, '0, 1'b1);
          end else begin
            for (idx = 0; idx < shadow_list.size(); idx++)
              owe_result(ST_OK, shadow_list[idx], idx == shadow_list.size() - 1);
          end
        end
        default: begin
        end
      endcase
    endfunction

    task report_mismatch(string msg);
      mismatch_count++;
      $display("MISMATCH: %s", msg);
    endtask

    // Compare one returned result with the oldest owed one.
    task check_result(logic [ST_W-1:0] st, logic [VAL_W-1:0] v, logic lst);
      list_result_t exp_r;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d value %08h last %0b",
                                  st, v, lst));
        return;
      end
      exp_r = pending_results.pop_front();
      if (st !== exp_r.status || v !== exp_r.value || lst !== exp_r.last)
        report_mismatch($sformatf("got status %0d value %08h last %0b, want %0d %08h %0b",
                                  st, v, lst, exp_r.status, exp_r.value, exp_r.last));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [CMD_W-1:0]      in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  list_scoreboard list_sb;
  int send_stretch = 0;
  int recv_stretch = 0;

  ordered_list_store_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Wait length for one handshake, with occasional runs of back-to-back traffic.
  function automatic int draw_wait(inout int stretch);
    if (stretch > 0) begin
      stretch--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      stretch = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  // Mix of arbitrary words, small values that repeat, and the extremes.
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7);
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0000_0000;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // Present one request and hold it until the core takes it.
  task automatic send_request(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] v,
                              logic [POS_W-1:0] pos);
    int gap;
    gap = draw_wait(send_stretch);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W - VAL_W - POS_W){1'b0}}, pos, v};
    in_tuser  <= cmd;
    do @(posedge clk); while (in_tready !== 1'b1);
    list_sb.note_request(cmd, v, pos);
  endtask

  // Corner cases: empty list, bad positions, extremes, full list.
  task automatic run_directed();
    int i;
    send_request(CMD_READ_ALL, '0, '0);
    send_request(CMD_POP_FRONT, '0, '0);
    send_request(CMD_POP_BACK, '0, '0);
    send_request(CMD_DELETE_VALUE, '0, '0);
    send_request(CMD_INSERT_AFTER, 32'h1, 5'd0);
    send_request(CMD_INSERT_AFTER, 32'h2, 5'd1);
    send_request(CMD_PUSH_FRONT, 32'h7FFF_FFFF, 5'd31);
    send_request(CMD_PUSH_BACK, 32'h8000_0000, 5'd0);
    send_request(CMD_INSERT_AFTER, 32'h3, 5'd0);
    // Insert after the tail, then in the middle.
    send_request(CMD_INSERT_AFTER, 32'hFFFF_FFFF, 5'd2);
    send_request(CMD_INSERT_AFTER, 32'h0, 5'd1);
    send_request(CMD_INSERT_AFTER, 32'h4, 5'd5);
    send_request(CMD_INSERT_AFTER, 32'h5555_5555, 5'd31);
    send_request(CMD_READ_ALL, 32'hAAAA_AAAA, 5'd21);
    // Deleting the front element by value, then a value that is absent.
    send_request(CMD_DELETE_VALUE, 32'h7FFF_FFFF, '0);
    send_request(CMD_DELETE_VALUE, 32'd12345, '0);
    send_request(CMD_POP_BACK, '0, '0);
    send_request(CMD_POP_FRONT, '0, '0);
    send_request(CMD_UNUSED, 32'hAAAA_AAAA, 5'd31);
    // Fill the list to capacity from both ends.
    for (i = 0; i < DEPTH - 1; i++)
      send_request(i[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT, 32'h1111_1111 * i, '0);
    send_request(CMD_PUSH_FRONT, 32'h9, '0);
    send_request(CMD_PUSH_BACK, 32'h9, '0);
    send_request(CMD_INSERT_AFTER, 32'h9, 5'd0);
    send_request(CMD_READ_ALL, '0, '0);
    send_request(CMD_DELETE_VALUE, 32'h5555_5555, '0);
    send_request(CMD_POP_FRONT, '0, '0);
    send_request(CMD_POP_BACK, '0, '0);
  endtask

  // Random requests; the insert share swings per segment so the list
  // repeatedly runs full and drains empty.
  task automatic run_random(int n_items);
    int sent;
    int push_pct;
    int n;
    logic [CMD_W-1:0] cmd;
    logic [VAL_W-1:0] v;
    logic [POS_W-1:0] pos;
    sent = 0;
    push_pct = 50;
    while (sent < n_items) begin
      if (sent % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: push_pct = 25;
          1: push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      n   = list_sb.shadow_list.size();
      v   = pick_value();
      pos = $urandom_range(0, 31);
      if ($urandom_range(0, 99) < 2) begin
        cmd = CMD_UNUSED;
      end else if ($urandom_range(0, 99) < push_pct) begin
        case ($urandom_range(0, 2))
          0: cmd = CMD_PUSH_FRONT;
          1: cmd = CMD_PUSH_BACK;
          default: begin
            cmd = CMD_INSERT_AFTER;
            if (n > 0 && $urandom_range(0, 4) != 0) pos = $urandom_range(1, n);
          end
        endcase
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2: cmd = CMD_POP_FRONT;
          3, 4, 5: cmd = CMD_POP_BACK;
          6, 7, 8: begin
            cmd = CMD_DELETE_VALUE;
            if (n > 0 && $urandom_range(0, 3) != 0)
              v = list_sb.shadow_list[$urandom_range(0, n - 1)];
          end
          default: cmd = CMD_READ_ALL;
        endcase
      end
      send_request(cmd, v, pos);
      if (cmd != CMD_UNUSED) sent++;
    end
  endtask

  // Result side: random stalls, check every accepted result.
  initial begin : result_sink
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_wait(recv_stretch);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      list_sb.check_result(out_tdata[ST_W-1:0], out_tdata[ST_W +: VAL_W], out_tlast);
    end
  end

  // Reset, stimulus, drain and verdict.
  initial begin : main_seq
    list_sb = new();
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    out_tready <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random(RANDOM_REQUESTS);
    in_tvalid <= 1'b0;
    while (list_sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (list_sb.mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin : watchdog
    #6000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
